FILE: hw/rtl/hsv_pkg.sv
package hsv_pkg;

  localparam int HueW   = 15;
  localparam int LevelW = 8;
  localparam int RemW   = 12;
  localparam int FracW  = 12;
  localparam int KeepW  = 20;

  localparam logic [HueW-1:0]  HueTurn   = 15'd23040;
  localparam logic [HueW-1:0]  HueSector = 15'd3840;
  localparam logic [12:0]      FracOne   = 13'd4096;
  localparam logic [KeepW-1:0] KeepOne   = 20'd1044480;

  // floor(x * 16 / 15) for x < 3840: x * ceil(2^19 / 15) >> 15
  localparam logic [15:0] FracRecip = 16'd34953;
  // floor(x / 255) for x < 65536: x * ceil(2^23 / 255) >> 23
  localparam logic [15:0] Div255Recip = 16'd32897;

  // Stage count from request accept to result strobe.
  localparam int PipeDepth = 6;

  typedef logic [2:0] sector_t;

  typedef struct packed {
    logic    valid;
    logic    grey;
    sector_t sector;
  } pix_meta_t;

  function automatic logic [LevelW-1:0] div255(input logic [15:0] x);
    logic [31:0] prod;
    prod = x * Div255Recip;
    return prod[30:23];
  endfunction

endpackage

FILE: hw/rtl/hsv_sector.sv
module hsv_sector (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [14:0]               hue,
  input  logic [7:0]                sat,
  input  logic [7:0]                val,
  output hsv_pkg::pix_meta_t        meta_out,
  output logic [hsv_pkg::FracW-1:0] frac_out,
  output logic [15:0]               prod_p_out,
  output logic [7:0]                sat_out,
  output logic [7:0]                val_out
);
  import hsv_pkg::*;

  logic [HueW-1:0] hue_c;
  sector_t         sector_c;
  logic [HueW-1:0] base_c;
  logic [HueW-1:0] rem_c;

  pix_meta_t       meta1;
  logic [RemW-1:0] rem1;
  logic [7:0]      sat1;
  logic [7:0]      val1;

  logic [27:0]     frac_prod;

  always_comb begin
    hue_c = (hue >= HueTurn) ? '0 : hue;
    priority if (hue_c >= 15'(5 * 3840)) begin
      sector_c = 3'd5;
      base_c   = 15'(5 * 3840);
    end else if (hue_c >= 15'(4 * 3840)) begin
      sector_c = 3'd4;
      base_c   = 15'(4 * 3840);
    end else if (hue_c >= 15'(3 * 3840)) begin
      sector_c = 3'd3;
      base_c   = 15'(3 * 3840);
    end else if (hue_c >= 15'(2 * 3840)) begin
      sector_c = 3'd2;
      base_c   = 15'(2 * 3840);
    end else if (hue_c >= HueSector) begin
      sector_c = 3'd1;
      base_c   = HueSector;
    end else begin
      sector_c = 3'd0;
      base_c   = '0;
    end
    rem_c = hue_c - base_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta1.valid <= 1'b0;
    end else begin
      meta1.valid <= in_valid;
    end
    meta1.grey   <= (sat == '0);
    meta1.sector <= sector_c;
    rem1         <= rem_c[RemW-1:0];
    sat1         <= sat;
    val1         <= val;
  end

  assign frac_prod = 28'(rem1) * 28'(FracRecip);

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_out.valid <= 1'b0;
    end else begin
      meta_out.valid <= meta1.valid;
    end
    meta_out.grey   <= meta1.grey;
    meta_out.sector <= meta1.sector;
    frac_out        <= frac_prod[26:15];
    prod_p_out      <= val1 * (8'd255 - sat1);
    sat_out         <= sat1;
    val_out         <= val1;
  end

endmodule

FILE: hw/rtl/hsv_level.sv
module hsv_level (
  input  logic                      clk,
  input  logic                      rst,
  input  hsv_pkg::pix_meta_t        meta_in,
  input  logic [hsv_pkg::FracW-1:0] frac_in,
  input  logic [15:0]               prod_p_in,
  input  logic [7:0]                sat_in,
  input  logic [7:0]                val_in,
  output hsv_pkg::pix_meta_t        meta_out,
  output logic [7:0]                p_out,
  output logic [7:0]                q_out,
  output logic [7:0]                t_out,
  output logic [7:0]                val_out
);
  import hsv_pkg::*;

  pix_meta_t        meta3;
  logic [KeepW-1:0] keep_q3;
  logic [KeepW-1:0] keep_t3;
  logic [7:0]       p3;
  logic [7:0]       val3;

  pix_meta_t        meta4;
  logic [27:0]      prod_q4;
  logic [27:0]      prod_t4;
  logic [7:0]       p4;
  logic [7:0]       val4;

  logic [KeepW-1:0] sf_c;
  logic [KeepW-1:0] sfc_c;

  assign sf_c  = KeepW'(sat_in) * KeepW'(frac_in);
  assign sfc_c = KeepW'(sat_in) * KeepW'(FracOne - 13'(frac_in));

  always_ff @(posedge clk) begin
    if (rst) begin
      meta3.valid <= 1'b0;
      meta4.valid <= 1'b0;
      meta_out.valid <= 1'b0;
    end else begin
      meta3.valid <= meta_in.valid;
      meta4.valid <= meta3.valid;
      meta_out.valid <= meta4.valid;
    end
    meta3.grey   <= meta_in.grey;
    meta3.sector <= meta_in.sector;
    keep_q3      <= KeepOne - sf_c;
    keep_t3      <= KeepOne - sfc_c;
    p3           <= div255(prod_p_in);
    val3         <= val_in;

    meta4.grey   <= meta3.grey;
    meta4.sector <= meta3.sector;
    prod_q4      <= 28'(val3) * 28'(keep_q3);
    prod_t4      <= 28'(val3) * 28'(keep_t3);
    p4           <= p3;
    val4         <= val3;

    // full scale is 255 * 4096: drop the 4096 by shift, then divide by 255
    meta_out.grey   <= meta4.grey;
    meta_out.sector <= meta4.sector;
    q_out           <= div255(prod_q4[27:12]);
    t_out           <= div255(prod_t4[27:12]);
    p_out           <= p4;
    val_out         <= val4;
  end

endmodule

FILE: hw/rtl/hsv_to_rgb_converter.sv
// HSV to RGB pixel converter.
// Request channel: hue (1/64 degree, 23040 or more reads as 0), sat and val
// (fractions of 255). A request is taken at a rising edge where start is
// high and busy is low. busy is high only while rst is high.
// Result channel: red, green and blue are valid for the single cycle in
// which done is high; the receiver must take them then, it cannot stall.
// Throughput: one pixel per clock, set by the fully pipelined datapath
// (sector split, fraction multiply, s*f products, v*keep products, divide
// by 255 through reciprocal multiplies, sector routing).
// Zero saturation yields red = green = blue = val.
// Reset clears every stage's valid bit, so requests in flight are dropped
// and done stays low until new requests come through.
module hsv_to_rgb_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [14:0] hue,
  input  logic [7:0]  sat,
  input  logic [7:0]  val,
  output logic        done,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);
  import hsv_pkg::*;

  pix_meta_t        meta2;
  logic [FracW-1:0] frac2;
  logic [15:0]      prod_p2;
  logic [7:0]       sat2;
  logic [7:0]       val2;

  pix_meta_t        meta5;
  logic [7:0]       p5;
  logic [7:0]       q5;
  logic [7:0]       t5;
  logic [7:0]       val5;

  logic [7:0]       red_next;
  logic [7:0]       green_next;
  logic [7:0]       blue_next;

  assign busy = rst;

  hsv_sector u_sector (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start & ~busy),
    .hue        (hue),
    .sat        (sat),
    .val        (val),
    .meta_out   (meta2),
    .frac_out   (frac2),
    .prod_p_out (prod_p2),
    .sat_out    (sat2),
    .val_out    (val2)
  );

  hsv_level u_level (
    .clk       (clk),
    .rst       (rst),
    .meta_in   (meta2),
    .frac_in   (frac2),
    .prod_p_in (prod_p2),
    .sat_in    (sat2),
    .val_in    (val2),
    .meta_out  (meta5),
    .p_out     (p5),
    .q_out     (q5),
    .t_out     (t5),
    .val_out   (val5)
  );

  always_comb begin
    if (meta5.grey) begin
      red_next   = val5;
      green_next = val5;
      blue_next  = val5;
    end else begin
      unique case (meta5.sector)
        3'd0: begin
          red_next = val5; green_next = t5;   blue_next = p5;
        end
        3'd1: begin
          red_next = q5;   green_next = val5; blue_next = p5;
        end
        3'd2: begin
          red_next = p5;   green_next = val5; blue_next = t5;
        end
        3'd3: begin
          red_next = p5;   green_next = q5;   blue_next = val5;
        end
        3'd4: begin
          red_next = t5;   green_next = p5;   blue_next = val5;
        end
        default: begin
          red_next = val5; green_next = p5;   blue_next = q5;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= meta5.valid;
    end
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
  end

endmodule

FILE: hw/rtl/hsv_checker.sv
module hsv_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [7:0]  sat,
  input logic [7:0]  val,
  input logic        done,
  input logic [7:0]  red,
  input logic [7:0]  green,
  input logic [7:0]  blue
);
  import hsv_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("done high right after reset");

  a_request_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PipeDepth done)
    else $error("request did not produce a result");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##PipeDepth !done)
    else $error("result without a request");

  a_grey: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && sat == 8'd0) |-> ##PipeDepth
      (red == $past(val, PipeDepth) && green == red && blue == red))
    else $error("grey pixel not equal to value");

endmodule

bind hsv_to_rgb_converter hsv_checker u_hsv_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .sat   (sat),
  .val   (val),
  .done  (done),
  .red   (red),
  .green (green),
  .blue  (blue)
);

FILE: test/hsv_to_rgb_converter_test.sv
module hsv_to_rgb_converter_test;

  localparam int HueTurn    = 23040;
  localparam int HueSector  = 3840;
  localparam int FracOne    = 4096;
  localparam int LevelOne   = 255;
  localparam int KeepOne    = 1044480;
  localparam int MaxGap     = 19;
  localparam int RandomReqs = 1550;

  typedef struct {
    logic [14:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    int          gap;
    bit          drain;
  } pixel_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [14:0] hue = '0;
  logic [7:0]  sat = '0;
  logic [7:0]  val = '0;
  logic        busy;
  logic        done;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  pixel_req_t pixel_reqs[$];
  rgb_t       rgb_due[$];
  rgb_t       oldest_due;
  int         reqs_issued = 0;
  int         reqs_taken = 0;
  int         reqs_total = 0;
  int         mismatches = 0;
  int         lead = -1;

  hsv_to_rgb_converter dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .hue   (hue),
    .sat   (sat),
    .val   (val),
    .done  (done),
    .red   (red),
    .green (green),
    .blue  (blue)
  );

  always #4 clk = ~clk;

  function automatic rgb_t rgb_of_hsv(logic [14:0] h_in, logic [7:0] s_in, logic [7:0] v_in);
    longint unsigned h, s, v, sector, rem, f, p, q, t;
    rgb_t px;
    h = h_in;
    s = s_in;
    v = v_in;
    if (s == 0) begin
      px.red   = v_in;
      px.green = v_in;
      px.blue  = v_in;
    end else begin
      if (h >= HueTurn) h = 0;
      sector = h / HueSector;
      rem    = h % HueSector;
      f      = (rem * FracOne) / HueSector;
      p      = (v * (LevelOne - s)) / LevelOne;
      q      = (v * (KeepOne - s * f)) / KeepOne;
      t      = (v * (KeepOne - s * (FracOne - f))) / KeepOne;
      case (sector)
        0: begin
          px.red = v[7:0]; px.green = t[7:0]; px.blue = p[7:0];
        end
        1: begin
          px.red = q[7:0]; px.green = v[7:0]; px.blue = p[7:0];
        end
        2: begin
          px.red = p[7:0]; px.green = v[7:0]; px.blue = t[7:0];
        end
        3: begin
          px.red = p[7:0]; px.green = q[7:0]; px.blue = v[7:0];
        end
        4: begin
          px.red = t[7:0]; px.green = p[7:0]; px.blue = v[7:0];
        end
        default: begin
          px.red = v[7:0]; px.green = p[7:0]; px.blue = q[7:0];
        end
      endcase
    end
    return px;
  endfunction

  task automatic compare_level(string channel, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, channel, want, got);
      mismatches++;
    end
  endtask

  task automatic queue_pixel(int h, int s, int v, int gap, bit drain);
    pixel_req_t req;
    req.hue   = h[14:0];
    req.sat   = s[7:0];
    req.val   = v[7:0];
    req.gap   = gap;
    req.drain = drain;
    pixel_reqs.push_back(req);
  endtask

  function automatic int draw_gap(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, MaxGap);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MaxGap) : 0;
    endcase
  endfunction

  function automatic int draw_level();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 255;
      2: return $urandom_range(1, 3);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int draw_hue();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return $urandom_range(0, HueTurn - 1);
    if (pick < 8) return $urandom_range(0, 6) * HueSector + $urandom_range(0, 4) - 2 + 2;
    return $urandom_range(HueTurn, 32767);
  endfunction

  // Drive requests at the falling edge; hold each one until the rising edge takes it.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && reqs_taken != reqs_issued) begin
      start <= 1'b1;
    end else begin
      if (lead < 0 && pixel_reqs.size() != 0) lead = pixel_reqs[0].gap;
      if (lead < 0) begin
        start <= 1'b0;
      end else if (lead > 0) begin
        lead--;
        start <= 1'b0;
      end else if (pixel_reqs[0].drain && rgb_due.size() != 0) begin
        start <= 1'b0;
      end else begin
        pixel_req_t req;
        req = pixel_reqs.pop_front();
        hue   <= req.hue;
        sat   <= req.sat;
        val   <= req.val;
        start <= 1'b1;
        reqs_issued++;
        lead = -1;
      end
    end
  end

  // Check results before logging a new request: latency keeps the two apart anyway.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (rgb_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0d %0d %0d",
                   $time, red, green, blue);
          mismatches++;
        end else begin
          oldest_due = rgb_due.pop_front();
          compare_level("red", oldest_due.red, red);
          compare_level("green", oldest_due.green, green);
          compare_level("blue", oldest_due.blue, blue);
        end
      end
      if (start && !busy) begin
        rgb_due.push_back(rgb_of_hsv(hue, sat, val));
        reqs_taken++;
      end
    end
  end

  initial begin
    int mode;
    // Directed: hue edges, sector borders, grey and full-saturation corners.
    queue_pixel(0, 255, 255, 0, 0);
    queue_pixel(HueSector - 1, 255, 255, 0, 0);
    queue_pixel(HueSector, 255, 255, 1, 0);
    queue_pixel(2 * HueSector, 255, 255, 0, 0);
    queue_pixel(3 * HueSector, 255, 255, 0, 0);
    queue_pixel(4 * HueSector, 255, 255, 2, 0);
    queue_pixel(5 * HueSector, 255, 255, 0, 0);
    queue_pixel(6 * HueSector - 1, 255, 255, 0, 0);
    queue_pixel(HueTurn, 255, 255, 0, 0);
    queue_pixel(32767, 255, 200, 3, 0);
    queue_pixel(32767, 0, 255, 0, 0);
    queue_pixel(12345, 0, 0, 0, 1);
    queue_pixel(25000, 0, 77, 0, 0);
    queue_pixel(1920, 1, 255, 0, 0);
    queue_pixel(9000, 128, 0, 5, 0);
    queue_pixel(HueSector + 1920, 255, 1, 0, 0);
    queue_pixel(7 * HueSector, 100, 150, 0, 0);
    queue_pixel(HueTurn - 1, 254, 254, 0, 0);
    queue_pixel(21845, 170, 85, 0, 0);
    queue_pixel(10922, 85, 170, 19, 0);
    mode = 0;
    for (int i = 0; i < RandomReqs; i++) begin
      if (i % 100 == 0) mode = $urandom_range(0, 2);
      queue_pixel(draw_hue(), draw_level(), draw_level(), draw_gap(mode), (i % 400) == 200);
    end
    reqs_total = pixel_reqs.size();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (reqs_taken != reqs_total || rgb_due.size() != 0) @(posedge clk);
    repeat (hsv_pkg::PipeDepth + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
